/* rtl/rau_pkg.sv */
// Shared types and constants of the rational arithmetic unit.
package rau_pkg;

	localparam int NumW = 32;
	localparam int DenW = 31;
	localparam int ResNumW = 64;
	localparam int ResDenW = 62;
	localparam int WideW = 64;
	localparam int CntW = 6;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_MUL,
		FR_SUM,
		FR_PUSH
	} fr_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_GCD,
		BK_DIVN,
		BK_DIVD,
		BK_FIN,
		BK_HOLD
	} bk_state_t;

	// Classified item handed from front to back.
	typedef struct packed {
		logic              zero;
		logic              neg;
		logic [WideW-1:0]  mag;
		logic [ResDenW-1:0] den;
	} rau_item_t;

	// Queue handshake between the two halves.
	typedef struct packed {
		logic push;
		logic pop;
	} rau_qreq_t;

	typedef struct packed {
		logic full;
		logic empty;
	} rau_qsts_t;

endpackage

/* rtl/rau_front.sv */
// Front end: accepts operands, forms raw numerator and denominator.
module rau_front import rau_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            operation,
	input  logic signed [NumW-1:0] left_num,
	input  logic [DenW-1:0]       left_den,
	input  logic signed [NumW-1:0] right_num,
	input  logic [DenW-1:0]       right_den,
	input  logic                  q_full,
	output logic                  q_push,
	output rau_item_t             q_item
);

	fr_state_t state_q, state_d;
	logic [1:0] step_q;
	logic [NumW-1:0] lmag_q, rmag_q;
	logic [DenW-1:0] ld_q, rd_q;
	logic s0_q, s1_q, use1_q, mul_rn_q, div_q;
	logic [WideW-1:0] p0_q, p1_q, p2_q;
	logic signed [WideW:0] sum_q;
	logic [NumW-1:0] ma, mb;
	logic [WideW-1:0] prod;
	logic signed [WideW:0] t0, t1;
	logic accept;

	assign accept = push && !full;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FR_IDLE: if (accept) state_d = FR_MUL;
			FR_MUL:  if (step_q == 2'd2) state_d = FR_SUM;
			FR_SUM:  state_d = FR_PUSH;
			FR_PUSH: if (!q_full) state_d = FR_IDLE;
			default: state_d = FR_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		full   = (state_q != FR_IDLE);
		q_push = (state_q == FR_PUSH) && !q_full;
	end

	// Select multiplier operands for each product
	always_comb begin
		case (step_q)
			2'd0: begin
				ma = lmag_q;
				mb = mul_rn_q ? rmag_q : {1'b0, rd_q};
			end
			2'd1: begin
				ma = rmag_q;
				mb = {1'b0, ld_q};
			end
			default: begin
				ma = {1'b0, ld_q};
				mb = div_q ? rmag_q : {1'b0, rd_q};
			end
		endcase
		prod = {{NumW{1'b0}}, ma} * {{NumW{1'b0}}, mb};
	end

	// Signed terms of the numerator
	always_comb begin
		t0 = s0_q ? -$signed({1'b0, p0_q}) : $signed({1'b0, p0_q});
		t1 = !use1_q ? '0 : (s1_q ? -$signed({1'b0, p1_q}) : $signed({1'b0, p1_q}));
	end

	// State and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) step_q <= '0;
			else if (state_q == FR_MUL) step_q <= step_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lmag_q   <= left_num[NumW-1] ? NumW'(-left_num) : NumW'(left_num);
			rmag_q   <= right_num[NumW-1] ? NumW'(-right_num) : NumW'(right_num);
			ld_q     <= left_den;
			rd_q     <= right_den;
			mul_rn_q <= (op_t'(operation) == OP_MUL);
			div_q    <= (op_t'(operation) == OP_DIV);
			use1_q   <= (op_t'(operation) == OP_ADD) || (op_t'(operation) == OP_SUB);
			s1_q     <= right_num[NumW-1] ^ (op_t'(operation) == OP_SUB);
			s0_q     <= left_num[NumW-1] ^ (right_num[NumW-1] &&
			            ((op_t'(operation) == OP_MUL) || (op_t'(operation) == OP_DIV)));
		end
		if (state_q == FR_MUL) begin
			case (step_q)
				2'd0: p0_q <= prod;
				2'd1: p1_q <= prod;
				default: p2_q <= prod;
			endcase
		end
		if (state_q == FR_SUM) sum_q <= t0 + t1;
	end

	// Build the queue entry
	always_comb begin
		q_item.zero = (p2_q == '0);
		q_item.neg  = sum_q[WideW];
		q_item.mag  = sum_q[WideW] ? WideW'(-sum_q) : WideW'(sum_q);
		q_item.den  = p2_q[ResDenW-1:0];
	end

endmodule

/* rtl/rau_queue.sv */
// Two-entry queue between front and back.
module rau_queue import rau_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rau_qreq_t req,
	output rau_qsts_t sts,
	input  rau_item_t wdata,
	output rau_item_t rdata
);

	rau_item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign sts.full  = (cnt_q == 2'd2);
	assign sts.empty = (cnt_q == 2'd0);
	assign wr = req.push && !sts.full;
	assign rd = req.pop && !sts.empty;
	assign rdata = mem_q[rp_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

endmodule

/* rtl/rau_back.sv */
// Back end: binary gcd, two restoring divisions and the result register.
module rau_back import rau_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_empty,
	output logic                     q_pop,
	input  rau_item_t                q_item,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [ResNumW-1:0] result_num,
	output logic [ResDenW-1:0]       result_den,
	output logic                     status
);

	bk_state_t state_q, state_d;
	logic [WideW-1:0] a_q, b_q, g_q, mag_q, den_q, magr_q;
	logic [CntW-1:0] k_q, cnt_q;
	logic neg_q;
	logic [WideW:0] rem_q;
	logic [WideW-1:0] quo_q;
	logic [WideW:0] trial;
	logic fits;
	logic [WideW:0] rem_n;
	logic [WideW-1:0] quo_n;
	logic take, gcd_done, div_last;

	assign take     = (state_q == BK_IDLE) && !q_empty;
	assign gcd_done = (a_q == '0);
	assign div_last = (cnt_q == CntW'(WideW - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (!q_empty) state_d = q_item.zero ? BK_HOLD : BK_GCD;
			BK_GCD:  if (gcd_done) state_d = BK_DIVN;
			BK_DIVN: if (div_last) state_d = BK_DIVD;
			BK_DIVD: if (div_last) state_d = BK_FIN;
			BK_FIN:  state_d = BK_HOLD;
			BK_HOLD: if (pop) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		q_pop = take;
		empty = (state_q != BK_HOLD);
	end

	// One restoring division step
	always_comb begin
		trial = {rem_q[WideW-1:0], quo_q[WideW-1]};
		fits  = (trial >= {1'b0, g_q});
		rem_n = fits ? trial - {1'b0, g_q} : trial;
		quo_n = {quo_q[WideW-2:0], fits};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_IDLE;
		else state_q <= state_d;
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				a_q   <= q_item.mag;
				b_q   <= {2'b00, q_item.den};
				mag_q <= q_item.mag;
				den_q <= {2'b00, q_item.den};
				neg_q <= q_item.neg;
				k_q   <= '0;
				if (!q_empty && q_item.zero) begin
					result_num <= '0;
					result_den <= ResDenW'(1);
					status     <= 1'b1;
				end
			end
			BK_GCD: begin
				if (gcd_done) begin
					g_q   <= b_q << k_q;
					quo_q <= mag_q;
					rem_q <= '0;
					cnt_q <= '0;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + CntW'(1);
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q >= b_q) begin
					a_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
			BK_DIVN: begin
				cnt_q <= cnt_q + CntW'(1);
				if (div_last) begin
					magr_q <= quo_n;
					quo_q  <= den_q;
					rem_q  <= '0;
				end else begin
					quo_q <= quo_n;
					rem_q <= rem_n;
				end
			end
			BK_DIVD: begin
				cnt_q <= cnt_q + CntW'(1);
				quo_q <= quo_n;
				rem_q <= rem_n;
			end
			BK_FIN: begin
				result_num <= neg_q ? -$signed(magr_q) : $signed(magr_q);
				result_den <= quo_q[ResDenW-1:0];
				status     <= 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

/* rtl/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit.
//
//  channel  | handshake      | beat payload
//  ---------+----------------+-----------------------------------------------
//  input    | push / full    | operation, left_num, left_den, right_num, right_den
//  result   | pop / empty    | result_num, result_den, status
//
// The front takes an item, forms its three products in turn on its shared 32x32
// multiplier, then forms the sum and pushes the queue entry; it accepts no new
// item before that entry is pushed. The back runs the binary gcd loop, then
// both divisions on the shared restoring divider, and holds the result until pop.
// A zero denominator skips gcd and division. Reset clears all control at once.
// A two-entry queue lets the front run ahead while a result waits for pop.
module rational_arithmetic_unit import rau_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic [1:0]               operation,
	input  logic signed [NumW-1:0]   left_num,
	input  logic [DenW-1:0]          left_den,
	input  logic signed [NumW-1:0]   right_num,
	input  logic [DenW-1:0]          right_den,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [ResNumW-1:0] result_num,
	output logic [ResDenW-1:0]       result_den,
	output logic                     status
);

	rau_qreq_t qreq;
	rau_qsts_t qsts;
	rau_item_t fr_item, bk_item;

	rau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.left_num  (left_num),
		.left_den  (left_den),
		.right_num (right_num),
		.right_den (right_den),
		.q_full    (qsts.full),
		.q_push    (qreq.push),
		.q_item    (fr_item)
	);

	rau_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (qreq),
		.sts    (qsts),
		.wdata  (fr_item),
		.rdata  (bk_item)
	);

	rau_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (qsts.empty),
		.q_pop      (qreq.pop),
		.q_item     (bk_item),
		.empty      (empty),
		.pop        (pop),
		.result_num (result_num),
		.result_den (result_den),
		.status     (status)
	);

endmodule

/* tb/rational_arithmetic_unit_tb.sv */
// Self-checking testbench of the rational arithmetic unit: random queue traffic against a fraction predictor.
module rational_arithmetic_unit_tb import rau_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WatchLimit = 20000;

	typedef struct {
		op_t              op;
		logic signed [31:0] ln;
		logic [30:0]      ld;
		logic signed [31:0] rn;
		logic [30:0]      rd;
	} fraction_op_t;

	typedef struct {
		logic signed [63:0] num;
		logic [61:0]        den;
		logic               st;
	} fraction_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [1:0] operation = '0;
	logic signed [31:0] left_num = '0;
	logic [30:0] left_den = 31'd1;
	logic signed [31:0] right_num = '0;
	logic [30:0] right_den = 31'd1;
	logic full, empty, status;
	logic signed [63:0] result_num;
	logic [61:0] result_den;

	fraction_op_t  pending_ops[$];
	fraction_res_t expected_fracs[$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit stim_done = 1'b0;
	bit hold_sender = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	rational_arithmetic_unit DUT (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Euclid reduction of the cross-multiplied fraction
	function automatic fraction_res_t reduce_fraction(fraction_op_t x);
		fraction_res_t r;
		longint n, d, a, b, t;
		longint ln, ld, rn, rd;
		bit neg;
		ln = x.ln;
		rn = x.rn;
		ld = longint'({1'b0, x.ld});
		rd = longint'({1'b0, x.rd});
		case (x.op)
			OP_ADD: begin n = ln * rd + rn * ld; d = ld * rd; end
			OP_SUB: begin n = ln * rd - rn * ld; d = ld * rd; end
			OP_MUL: begin n = ln * rn; d = ld * rd; end
			default: begin
				n = ln * rd;
				d = ld * rn;
				if (d < 0) begin d = -d; n = -n; end
			end
		endcase
		if (d == 0) begin
			r.num = 0; r.den = 62'd1; r.st = 1'b1;
			return r;
		end
		neg = n < 0;
		a = neg ? -n : n;
		b = d;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		n = (neg ? -n : n) / a;
		d = d / a;
		r.num = neg ? -n : n;
		r.den = d[61:0];
		r.st = 1'b0;
		return r;
	endfunction

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 45) return 0;
		if (k < 90) return $urandom_range(1, 4);
		return $urandom_range(20, 400);
	endfunction

	function automatic logic signed [31:0] rand_num();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 20) - 10;
			1: return 32'sh8000_0000;
			2: return 32'sh7fff_ffff;
			3: return $urandom_range(0, 2000) - 1000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] rand_den();
		case ($urandom_range(0, 4))
			0: return 31'($urandom_range(1, 12));
			1: return 31'h7fff_ffff;
			2: return 31'($urandom_range(0, 3));
			default: return 31'($urandom);
		endcase
	endfunction

	task automatic add_op(op_t op, logic signed [31:0] ln, logic [30:0] ld,
			logic signed [31:0] rn, logic [30:0] rd);
		fraction_op_t x;
		x.op = op; x.ln = ln; x.ld = ld; x.rn = rn; x.rd = rd;
		pending_ops.push_back(x);
	endtask

	// Fill the stimulus queue: directed corners, a drain pause, then random
	initial begin
		fraction_op_t x;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		add_op(OP_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);
		add_op(OP_SUB, 32'sd1, 31'd2, 32'sd1, 31'd2);
		add_op(OP_MUL, -32'sd3, 31'd4, 32'sd8, 31'd9);
		add_op(OP_DIV, 32'sd1, 31'd2, -32'sd3, 31'd4);
		add_op(OP_DIV, 32'sd5, 31'd7, 32'sd0, 31'd1);
		add_op(OP_ADD, 32'sd0, 31'd5, 32'sd0, 31'd9);
		add_op(OP_ADD, 32'sd3, 31'd0, 32'sd1, 31'd1);
		add_op(OP_MUL, 32'sd3, 31'd1, 32'sd1, 31'd0);
		add_op(OP_ADD, 32'sh8000_0000, 31'h7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff);
		add_op(OP_SUB, 32'sh8000_0000, 31'h7fff_ffff, 32'sh7fff_ffff, 31'd1);
		add_op(OP_MUL, 32'sh8000_0000, 31'd1, 32'sh8000_0000, 31'd1);
		add_op(OP_MUL, 32'sh7fff_ffff, 31'h7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff);
		add_op(OP_DIV, 32'sh8000_0000, 31'h7fff_ffff, 32'sh8000_0000, 31'd1);
		add_op(OP_DIV, 32'sh7fff_ffff, 31'd1, 32'sh8000_0000, 31'h7fff_ffff);
		add_op(OP_DIV, -32'sd6, 31'd0, 32'sd2, 31'd3);
		add_op(OP_SUB, -32'sd1, 31'd1, 32'sd1, 31'd1);
		add_op(OP_ADD, 32'sd6, 31'd4, 32'sd10, 31'd8);
		add_op(OP_DIV, 32'sd0, 31'd3, -32'sd5, 31'd9);
		while (pending_ops.size() != 0 || expected_fracs.size() != 0)
			@(posedge clk);
		// once every result has drained, hold the sender for a pause
		hold_sender = 1'b1;
		repeat (50) @(posedge clk);
		hold_sender = 1'b0;
		repeat (950) begin
			x.op = op_t'($urandom_range(0, 3));
			x.ln = rand_num();
			x.ld = rand_den();
			x.rn = rand_num();
			x.rd = rand_den();
			pending_ops.push_back(x);
		end
		while (pending_ops.size() != 0) @(posedge clk);
		stim_done = 1'b1;
	end

	// Record each accepted beat and draw the gap before the next one
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			expected_fracs.push_back(reduce_fraction(pending_ops.pop_front()));
			send_gap <= pick_gap();
		end else if (send_gap > 0 && !push) begin
			send_gap <= send_gap - 1;
		end
	end

	// Drive beats and pop at the falling edge, with random gaps between them
	always @(negedge clk) begin
		if (!arst_n || hold_sender || pending_ops.size() == 0 || send_gap > 0) begin
			push <= 1'b0;
		end else begin
			push <= 1'b1;
			operation <= pending_ops[0].op;
			left_num <= pending_ops[0].ln;
			left_den <= pending_ops[0].ld;
			right_num <= pending_ops[0].rn;
			right_den <= pending_ops[0].rd;
		end
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (recv_gap > 0) begin
			pop <= 1'b0;
			recv_gap <= recv_gap - 1;
		end else begin
			pop <= 1'b1;
			if ($urandom_range(0, 9) == 0) recv_gap <= pick_gap();
		end
	end

	// Check each result beat against the oldest prediction
	always @(posedge clk) begin
		fraction_res_t e;
		if (arst_n && pop && !empty) begin
			if (expected_fracs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %0d/%0d st %0b",
						result_num, result_den, status);
			end else begin
				e = expected_fracs.pop_front();
				if (result_num !== e.num || result_den !== e.den || status !== e.st) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d/%0d st %0b, got %0d/%0d st %0b",
							e.num, e.den, e.st, result_num, result_den, status);
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat, and end of run
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || !arst_n || hold_sender)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("rational_arithmetic_unit verification failed");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (expected_fracs.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_fracs.size() == 0)
			$display("rational_arithmetic_unit verification clean");
		else
			$display("rational_arithmetic_unit verification failed");
		$finish;
	end

endmodule

/* files.f */
rtl/rau_pkg.sv
rtl/rau_front.sv
rtl/rau_queue.sv
rtl/rau_back.sv
rtl/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_tb.sv
